>>> rtl/ppcs_pkg.sv
`timescale 1ns / 1ps

package ppcs_pkg;

    // Field widths of the channels.
    localparam int OP_W       = 2;
    localparam int TIME_W     = 32;
    localparam int TOKEN_W    = 16;
    localparam int KIND_W     = 2;
    localparam int ARG_W      = 16;
    localparam int ID_W       = 32;
    localparam int MODCOUNT_W = 5;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int STAGE_W    = 3;

    // Operation codes of an input beat.
    localparam logic [OP_W-1:0] OP_TICK    = 2'd0;
    localparam logic [OP_W-1:0] OP_CONSOLE = 2'd1;
    localparam logic [OP_W-1:0] OP_START   = 2'd2;

    // Command kinds.
    localparam logic [KIND_W-1:0] KIND_POWER   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_BATTERY = 2'd1;
    localparam logic [KIND_W-1:0] KIND_STATUS  = 2'd2;
    localparam logic [KIND_W-1:0] KIND_CONSOLE = 2'd3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_POWER_IV   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BATTERY_IV = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_STATUS_IV  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BATTERY_EN = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_STATUS_EN  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_MOD_COUNT  = 3'd5;

    // Boot sequence stages.
    localparam logic [STAGE_W-1:0] STAGE_POWER     = 3'd0;
    localparam logic [STAGE_W-1:0] STAGE_BATTERY   = 3'd1;
    localparam logic [STAGE_W-1:0] STAGE_STATUS    = 3'd2;
    localparam logic [STAGE_W-1:0] STAGE_DISCOVERY = 3'd3;
    localparam logic [STAGE_W-1:0] STAGE_DONE      = 3'd4;

    // Timing constants in milliseconds.
    localparam logic [TIME_W-1:0] BOOT_POWER_MS     = 32'd20000;
    localparam logic [TIME_W-1:0] BOOT_BATTERY_MS   = 32'd25000;
    localparam logic [TIME_W-1:0] BOOT_STATUS_MS    = 32'd45000;
    localparam logic [TIME_W-1:0] BOOT_DISCOVERY_MS = 32'd50000;
    localparam logic [TIME_W-1:0] SEND_GAP_MS       = 32'd1000;

    // Reset values of the configuration registers.
    localparam logic [TIME_W-1:0]     RST_POWER_IV   = 32'd10000;
    localparam logic [TIME_W-1:0]     RST_BATTERY_IV = 32'd30000;
    localparam logic [TIME_W-1:0]     RST_STATUS_IV  = 32'd60000;
    localparam logic [MODCOUNT_W-1:0] RST_MOD_COUNT  = 5'd1;

    // One queue entry.
    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [ARG_W-1:0]  arg;
    } t_entry;

endpackage

>>> rtl/ppcs_intf.sv
`timescale 1ns / 1ps

// Input item channel.
interface ppcs_in_if import ppcs_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [OP_W-1:0]    operation;
    logic [TIME_W-1:0]  now_ms;
    logic               link_busy;
    logic               link_accepts;
    logic [TOKEN_W-1:0] console_token;

    modport source (output valid, operation, now_ms, link_busy, link_accepts,
                    console_token, input ready);
    modport sink   (input valid, operation, now_ms, link_busy, link_accepts,
                    console_token, output ready);
endinterface

// Result channel. The queue level width follows the queue depth.
interface ppcs_out_if import ppcs_pkg::*; #(
    parameter int QUEUE_DEPTH = 64
) ();
    localparam int LEVEL_W = $clog2(QUEUE_DEPTH + 1);

    logic               valid;
    logic               ready;
    logic               send_valid;
    logic [KIND_W-1:0]  send_kind;
    logic [ARG_W-1:0]   send_arg;
    logic [ID_W-1:0]    send_id;
    logic               send_accepted;
    logic               discovery_start;
    logic               queue_dropped;
    logic [LEVEL_W-1:0] queue_level;

    modport source (output valid, send_valid, send_kind, send_arg, send_id,
                    send_accepted, discovery_start, queue_dropped, queue_level,
                    input ready);
    modport sink   (input valid, send_valid, send_kind, send_arg, send_id,
                    send_accepted, discovery_start, queue_dropped, queue_level,
                    output ready);
endinterface

// Configuration write channel.
interface ppcs_cfg_if import ppcs_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

>>> rtl/periodic_poll_command_scheduler.sv
`timescale 1ns / 1ps
// Start, console, busy, unknown and boot-stage beats are captured, decoded in S_DECODE and loaded in S_FINISH.
// A tick that runs the cyclic polls passes S_POWER, S_BATT_CHK, S_STAT_CHK and S_SEND, with one push state
// per queued battery or status poll, up to min(module_count, MAX_MODULES) of each, as the queue has one write port.
// One item at a time; the result is loaded once the output register is free, and the next beat is taken the cycle after.
// Reset (synchronous, active low) loads the configuration defaults and empties the queue;
// the queue memory itself is not cleared, so no clearing pass is needed.

module periodic_poll_command_scheduler import ppcs_pkg::*; #(
    parameter int QUEUE_DEPTH = 64,
    parameter int MAX_MODULES = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    ppcs_in_if.sink      i_in,
    ppcs_cfg_if.sink     i_cfg,
    ppcs_out_if.source   o_out
);

    // Queue pointer and fill count widths. The count must be able to hold the depth itself.
    localparam int QW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    // Sequencer states.
    localparam logic [3:0] S_IDLE      = 4'd0;
    localparam logic [3:0] S_DECODE    = 4'd1;
    localparam logic [3:0] S_POWER     = 4'd2;
    localparam logic [3:0] S_BATT_CHK  = 4'd3;
    localparam logic [3:0] S_BATT_PUSH = 4'd4;
    localparam logic [3:0] S_STAT_CHK  = 4'd5;
    localparam logic [3:0] S_STAT_PUSH = 4'd6;
    localparam logic [3:0] S_SEND      = 4'd7;
    localparam logic [3:0] S_FINISH    = 4'd8;

    // Configuration registers.
    logic [TIME_W-1:0]     r_power_iv;
    logic [TIME_W-1:0]     r_battery_iv;
    logic [TIME_W-1:0]     r_status_iv;
    logic                  r_battery_en;
    logic                  r_status_en;
    logic [MODCOUNT_W-1:0] r_mod_count;

    // Scheduler state.
    logic [3:0]        r_state, n_state;
    logic [TIME_W-1:0] r_boot_time, n_boot_time;
    logic [TIME_W-1:0] r_last_power, n_last_power;
    logic [TIME_W-1:0] r_last_battery, n_last_battery;
    logic [TIME_W-1:0] r_last_status, n_last_status;
    logic [TIME_W-1:0] r_last_send, n_last_send;
    logic [STAGE_W-1:0] r_stage, n_stage;
    logic [QW-1:0]     r_head, n_head;
    logic [QW-1:0]     r_tail, n_tail;
    logic [CW-1:0]     r_count, n_count;
    logic [ID_W-1:0]   r_next_id, n_next_id;

    // Captured input beat.
    logic [OP_W-1:0]    r_op;
    logic [TIME_W-1:0]  r_now;
    logic               r_busy;
    logic               r_accepts;
    logic [TOKEN_W-1:0] r_token;

    // Per-item flags and round counter.
    logic                  r_sent, n_sent;
    logic [ID_W-1:0]       r_sent_id, n_sent_id;
    logic                  r_disc, n_disc;
    logic                  r_dropped, n_dropped;
    logic [MODCOUNT_W-1:0] r_mod, n_mod;

    // Output register.
    logic              r_o_valid, n_o_valid;
    logic              r_o_send_valid;
    logic [KIND_W-1:0] r_o_kind;
    logic [ARG_W-1:0]  r_o_arg;
    logic [ID_W-1:0]   r_o_id;
    logic              r_o_accepted;
    logic              r_o_disc;
    logic              r_o_dropped;
    logic [CW-1:0]     r_o_level;
    logic              out_load;

    // Queue memory, one write port at the tail and one registered read port at the head.
    t_entry r_mem [QUEUE_DEPTH];
    t_entry r_rd_data;
    logic   mem_we;
    logic   rd_en;

    // Shared push request.
    logic              push_req;
    logic [KIND_W-1:0] push_kind;
    logic [ARG_W-1:0]  push_arg;

    logic                  in_fire;
    logic [TIME_W-1:0]     since_boot;
    logic [MODCOUNT_W-1:0] round_n;

    assign in_fire     = i_in.valid && i_in.ready;
    assign i_in.ready  = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;
    assign since_boot  = r_now - r_boot_time;

    // A round polls min(module_count, MAX_MODULES) modules.
    assign round_n = (32'(r_mod_count) > MAX_MODULES) ? MODCOUNT_W'(MAX_MODULES) : r_mod_count;

    always_comb begin
        n_state        = r_state;
        n_boot_time    = r_boot_time;
        n_last_power   = r_last_power;
        n_last_battery = r_last_battery;
        n_last_status  = r_last_status;
        n_last_send    = r_last_send;
        n_stage        = r_stage;
        n_head         = r_head;
        n_tail         = r_tail;
        n_count        = r_count;
        n_next_id      = r_next_id;
        n_sent         = r_sent;
        n_sent_id      = r_sent_id;
        n_disc         = r_disc;
        n_dropped      = r_dropped;
        n_mod          = r_mod;
        n_o_valid      = r_o_valid;
        push_req       = 1'b0;
        push_kind      = KIND_POWER;
        push_arg       = '0;
        mem_we         = 1'b0;
        rd_en          = 1'b0;
        out_load       = 1'b0;

        if (o_out.ready) begin
            n_o_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    n_sent    = 1'b0;
                    n_disc    = 1'b0;
                    n_dropped = 1'b0;
                    n_state   = S_DECODE;
                end
            end
            S_DECODE: begin
                n_state = S_FINISH;
                case (r_op)
                    OP_START: begin
                        n_boot_time    = r_now;
                        n_last_power   = r_now;
                        n_last_battery = r_now;
                        n_last_status  = r_now;
                        n_stage        = STAGE_POWER;
                        n_head         = '0;
                        n_tail         = '0;
                        n_count        = '0;
                    end
                    OP_CONSOLE: begin
                        push_req  = 1'b1;
                        push_kind = KIND_CONSOLE;
                        push_arg  = r_token;
                    end
                    OP_TICK: begin
                        if (!r_busy) begin
                            // Each boot stage that is due ends the tick at once.
                            if (r_stage == STAGE_POWER && since_boot >= BOOT_POWER_MS) begin
                                push_req  = 1'b1;
                                push_kind = KIND_POWER;
                                n_stage   = STAGE_BATTERY;
                            end else if (r_stage == STAGE_BATTERY
                                         && since_boot >= BOOT_BATTERY_MS) begin
                                push_req  = 1'b1;
                                push_kind = KIND_BATTERY;
                                push_arg  = ARG_W'(1);
                                n_stage   = STAGE_STATUS;
                            end else if (r_stage == STAGE_STATUS
                                         && since_boot >= BOOT_STATUS_MS) begin
                                push_req  = 1'b1;
                                push_kind = KIND_STATUS;
                                push_arg  = ARG_W'(1);
                                n_stage   = STAGE_DISCOVERY;
                            end else if (r_stage == STAGE_DISCOVERY
                                         && since_boot >= BOOT_DISCOVERY_MS) begin
                                n_disc  = 1'b1;
                                n_stage = STAGE_DONE;
                            end else begin
                                n_state = S_POWER;
                            end
                        end
                    end
                    default: begin
                        n_state = S_FINISH;
                    end
                endcase
            end
            S_POWER: begin
                if (r_now - r_last_power >= r_power_iv) begin
                    push_req     = 1'b1;
                    push_kind    = KIND_POWER;
                    n_last_power = r_now;
                end
                n_state = S_BATT_CHK;
            end
            S_BATT_CHK: begin
                n_state = S_STAT_CHK;
                if (r_now - r_last_battery >= r_battery_iv) begin
                    n_last_battery = r_now;
                    if (r_battery_en && round_n != '0) begin
                        n_mod   = MODCOUNT_W'(1);
                        n_state = S_BATT_PUSH;
                    end
                end
            end
            S_BATT_PUSH: begin
                push_req  = 1'b1;
                push_kind = KIND_BATTERY;
                push_arg  = ARG_W'(r_mod);
                n_mod     = r_mod + MODCOUNT_W'(1);
                if (r_mod == round_n) begin
                    n_state = S_STAT_CHK;
                end
            end
            S_STAT_CHK: begin
                n_state = S_SEND;
                if (r_now - r_last_status >= r_status_iv) begin
                    n_last_status = r_now;
                    if (r_status_en && round_n != '0) begin
                        n_mod   = MODCOUNT_W'(1);
                        n_state = S_STAT_PUSH;
                    end
                end
            end
            S_STAT_PUSH: begin
                push_req  = 1'b1;
                push_kind = KIND_STATUS;
                push_arg  = ARG_W'(r_mod);
                n_mod     = r_mod + MODCOUNT_W'(1);
                if (r_mod == round_n) begin
                    n_state = S_SEND;
                end
            end
            S_SEND: begin
                // The head entry is read here and shows up in r_rd_data in the next cycle.
                // Every push of this item was written in an earlier cycle, so the read
                // never overlaps a write to the same entry.
                if (r_count != '0 && r_now - r_last_send >= SEND_GAP_MS) begin
                    rd_en     = 1'b1;
                    n_head    = (r_head == QW'(QUEUE_DEPTH - 1)) ? '0 : r_head + QW'(1);
                    n_count   = r_count - CW'(1);
                    n_sent    = 1'b1;
                    n_sent_id = r_next_id;
                    n_next_id = r_next_id + ID_W'(1);
                    if (r_accepts) begin
                        n_last_send = r_now;
                    end
                end
                n_state = S_FINISH;
            end
            S_FINISH: begin
                // Wait until the output register is free or being drained.
                if (!r_o_valid || o_out.ready) begin
                    out_load  = 1'b1;
                    n_o_valid = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // A full queue drops the new entry and flags it for this item.
        if (push_req) begin
            if (r_count == CW'(QUEUE_DEPTH)) begin
                n_dropped = 1'b1;
            end else begin
                mem_we  = 1'b1;
                n_tail  = (r_tail == QW'(QUEUE_DEPTH - 1)) ? '0 : r_tail + QW'(1);
                n_count = r_count + CW'(1);
            end
        end
    end

    // Control and state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_boot_time    <= '0;
            r_last_power   <= '0;
            r_last_battery <= '0;
            r_last_status  <= '0;
            r_last_send    <= '0;
            r_stage        <= STAGE_POWER;
            r_head         <= '0;
            r_tail         <= '0;
            r_count        <= '0;
            r_next_id      <= '0;
            r_sent         <= 1'b0;
            r_disc         <= 1'b0;
            r_dropped      <= 1'b0;
            r_mod          <= '0;
            r_o_valid      <= 1'b0;
        end else begin
            r_state        <= n_state;
            r_boot_time    <= n_boot_time;
            r_last_power   <= n_last_power;
            r_last_battery <= n_last_battery;
            r_last_status  <= n_last_status;
            r_last_send    <= n_last_send;
            r_stage        <= n_stage;
            r_head         <= n_head;
            r_tail         <= n_tail;
            r_count        <= n_count;
            r_next_id      <= n_next_id;
            r_sent         <= n_sent;
            r_disc         <= n_disc;
            r_dropped      <= n_dropped;
            r_mod          <= n_mod;
            r_o_valid      <= n_o_valid;
        end
    end

    // Configuration registers. The user must write them only while the block is idle; the block itself does not enforce it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_power_iv   <= RST_POWER_IV;
            r_battery_iv <= RST_BATTERY_IV;
            r_status_iv  <= RST_STATUS_IV;
            r_battery_en <= 1'b1;
            r_status_en  <= 1'b1;
            r_mod_count  <= RST_MOD_COUNT;
        end else if (i_cfg.valid && i_cfg.ready) begin
            case (i_cfg.index)
                REG_POWER_IV:   r_power_iv   <= i_cfg.data;
                REG_BATTERY_IV: r_battery_iv <= i_cfg.data;
                REG_STATUS_IV:  r_status_iv  <= i_cfg.data;
                REG_BATTERY_EN: r_battery_en <= i_cfg.data[0];
                REG_STATUS_EN:  r_status_en  <= i_cfg.data[0];
                REG_MOD_COUNT:  r_mod_count  <= i_cfg.data[MODCOUNT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Payload registers: input capture, send id and the result fields.
    always_ff @(posedge i_clk) begin
        r_sent_id <= n_sent_id;
        if (in_fire) begin
            r_op      <= i_in.operation;
            r_now     <= i_in.now_ms;
            r_busy    <= i_in.link_busy;
            r_accepts <= i_in.link_accepts;
            r_token   <= i_in.console_token;
        end
        if (out_load) begin
            r_o_send_valid <= r_sent;
            r_o_kind       <= r_sent ? r_rd_data.kind : KIND_POWER;
            r_o_arg        <= r_sent ? r_rd_data.arg : '0;
            r_o_id         <= r_sent ? r_sent_id : '0;
            r_o_accepted   <= r_sent && r_accepts;
            r_o_disc       <= r_disc;
            r_o_dropped    <= r_dropped;
            r_o_level      <= r_count;
        end
    end

    // Queue memory.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[r_tail] <= t_entry'{kind: push_kind, arg: push_arg};
        end
        if (rd_en) begin
            r_rd_data <= r_mem[r_head];
        end
    end

    assign o_out.valid           = r_o_valid;
    assign o_out.send_valid      = r_o_send_valid;
    assign o_out.send_kind       = r_o_kind;
    assign o_out.send_arg        = r_o_arg;
    assign o_out.send_id         = r_o_id;
    assign o_out.send_accepted   = r_o_accepted;
    assign o_out.discovery_start = r_o_disc;
    assign o_out.queue_dropped   = r_o_dropped;
    assign o_out.queue_level     = r_o_level;

    // The fill count never goes past the depth.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(QUEUE_DEPTH))
        else $error("queue count above depth");

    // A write into the queue only happens when there is room.
    a_write_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we |-> (r_count < CW'(QUEUE_DEPTH)))
        else $error("queue write while full");

    // A head read only happens when an entry is waiting, and consumes one id.
    a_read_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rd_en |-> (r_count != '0))
        else $error("queue read while empty");

    a_id_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rd_en |=> (r_next_id == $past(r_next_id) + ID_W'(1)))
        else $error("command id did not advance on send");

    // An empty queue has its pointers together.
    a_empty_ptrs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0) |-> (r_head == r_tail))
        else $error("empty queue with pointers apart");

endmodule
